[rtl/core/sed_pkg.sv]
// Shared types and constants for the Sobel edge magnitude stream block.
package sed_pkg;

   localparam int unsigned CSR_W          = 11;
   localparam logic [10:0] LINE_RESET     = 11'd640;
   localparam int unsigned CMP_W          = 14;
   localparam logic [13:0] LINE_MIN       = 14'd3;
   localparam int unsigned SQ_W           = 21;
   localparam int unsigned ROOT_W         = 12;
   localparam logic [20:0] SQRT_TOP_BIT   = 21'h100000;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] magnitude;
      logic       window_inside;
      logic       saturated;
   } rsp_type;

   typedef struct packed {
      logic [7:0] top;
      logic [7:0] mid;
      logic [7:0] bot;
   } column_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_READ = 6'b000010,
      S_GRAD = 6'b000100,
      S_SQ   = 6'b001000,
      S_ROOT = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

endpackage

[rtl/core/sed_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sed_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sed_cell.sv]
// One column cell of the 3x3 window; it passes its column to the next cell on a shift.
module sed_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  sed_pkg::column_type col_in,
   output sed_pkg::column_type col_out
);
   import sed_pkg::*;

   column_type col_ff;
   column_type col_in_w;

   assign col_in_w = shift ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_w;
      end
   end

   assign col_out = col_ff;

endmodule

[rtl/core/sed_sqrt.sv]
// Iterative ceiling square root, one result bit per step over eleven steps.
module sed_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sed_pkg::SQ_W-1:0]    square,
   output logic                        done,
   output logic [sed_pkg::ROOT_W-1:0]  root
);
   import sed_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [SQ_W-1:0]     rem_ff;
   logic [SQ_W:0]       root_ff;
   logic [SQ_W-1:0]     bit_ff;
   logic [ROOT_W-1:0]   result_ff;
   logic [SQ_W:0]       trial;
   logic [SQ_W-1:0]     rem_in;
   logic [SQ_W:0]       root_in;
   logic [ROOT_W-1:0]   result_in;

   always_comb begin
      trial = root_ff + {1'b0, bit_ff};
      if ({1'b0, rem_ff} >= trial) begin
         rem_in  = rem_ff - trial[SQ_W-1:0];
         root_in = (root_ff >> 1) + {1'b0, bit_ff};
      end else begin
         rem_in  = rem_ff;
         root_in = root_ff >> 1;
      end
      // The floor root leaves a remainder; any remainder rounds the root up.
      result_in = {1'b0, root_in[ROOT_W-2:0]} + {{(ROOT_W-1){1'b0}}, (rem_in != '0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= square;
         root_ff <= '0;
         bit_ff  <= SQRT_TOP_BIT;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         bit_ff  <= bit_ff >> 2;
         if (bit_ff[0]) begin
            result_ff <= result_in;
         end
      end
   end

   assign done = done_ff;
   assign root = result_ff;

endmodule

[rtl/core/sobel_edge_magnitude_stream_top.sv]
// Sobel 3x3 edge magnitude on a raster pixel stream: line stores, window cells, root unit.
// req_stall holds off a new item until the previous one has passed the eleven-step root unit and left S_DONE.
// The input side takes the next item while the previous result still waits on rsp_stall.
// Reset is synchronous: window, counters and line_width (640) are cleared; line stores are not.
module sobel_edge_magnitude_stream_top #(
   parameter int unsigned MAX_LINE = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sed_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sed_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [sed_pkg::CSR_W-1:0]   csr_write_data
);
   import sed_pkg::*;

   localparam int unsigned AW = $clog2(MAX_LINE);
   localparam logic [CMP_W-1:0] LINE_MAX = CMP_W'(MAX_LINE);

   state_type          state_ff, state_in;
   logic [CSR_W-1:0]   line_width_ff;
   logic [AW-1:0]      col_ff, col_in;
   logic [1:0]         rows_ff, rows_in;
   logic [AW-1:0]      addr_ff;
   logic [7:0]         px_ff;
   logic               inside_ff;
   logic signed [10:0] gx_ff, gy_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               accept;
   logic [AW-1:0]      cur_col;
   logic [1:0]         cur_rows;
   logic [CMP_W-1:0]   width_eff;
   logic [CMP_W-1:0]   col_plus;
   logic [7:0]         top_rd, mid_rd;
   column_type         new_col, col2, col1, col0;
   logic [10:0]        gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [SQ_W-1:0] gx_sq, gy_sq;
   logic [SQ_W-1:0]    square;
   logic               root_done;
   logic [ROOT_W-1:0]  root;
   logic               out_free;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign cur_col  = req_payload.frame_start ? '0 : col_ff;
   assign cur_rows = req_payload.frame_start ? 2'd0 : rows_ff;
   assign col_plus = CMP_W'(cur_col) + CMP_W'(1);

   always_comb begin
      width_eff = CMP_W'(line_width_ff);
      if (width_eff < LINE_MIN) begin
         width_eff = LINE_MIN;
      end
      if (width_eff > LINE_MAX) begin
         width_eff = LINE_MAX;
      end
      if (col_plus >= width_eff) begin
         col_in  = '0;
         rows_in = (cur_rows == 2'd2) ? cur_rows : cur_rows + 2'd1;
      end else begin
         col_in  = col_plus[AW-1:0];
         rows_in = cur_rows;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_RESET;
      end else if (csr_write_enable) begin
         line_width_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= 2'd0;
      end else if (accept) begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= cur_col;
         px_ff     <= req_payload.pixel;
         inside_ff <= (cur_rows == 2'd2) && (cur_col >= AW'(2));
      end
   end

   // The older row moves from the middle store to the top store as the new pixel lands.
   sed_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_top_ram (
      .clock  (clock),
      .wr_en  (state_ff == S_READ),
      .wr_addr(addr_ff),
      .wr_data(mid_rd),
      .rd_addr(cur_col),
      .rd_data(top_rd)
   );

   sed_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_mid_ram (
      .clock  (clock),
      .wr_en  (state_ff == S_READ),
      .wr_addr(addr_ff),
      .wr_data(px_ff),
      .rd_addr(cur_col),
      .rd_data(mid_rd)
   );

   assign new_col.top = top_rd;
   assign new_col.mid = mid_rd;
   assign new_col.bot = px_ff;

   sed_cell u_cell2 (
      .clock(clock), .reset(reset), .shift(state_ff == S_READ), .col_in(new_col), .col_out(col2)
   );
   sed_cell u_cell1 (
      .clock(clock), .reset(reset), .shift(state_ff == S_READ), .col_in(col2), .col_out(col1)
   );
   sed_cell u_cell0 (
      .clock(clock), .reset(reset), .shift(state_ff == S_READ), .col_in(col1), .col_out(col0)
   );

   assign gx_pos = 11'(col2.top) + {2'b0, col2.mid, 1'b0} + 11'(col2.bot);
   assign gx_neg = 11'(col0.top) + {2'b0, col0.mid, 1'b0} + 11'(col0.bot);
   assign gy_pos = 11'(col0.bot) + {2'b0, col1.bot, 1'b0} + 11'(col2.bot);
   assign gy_neg = 11'(col0.top) + {2'b0, col1.top, 1'b0} + 11'(col2.top);

   always_ff @(posedge clock) begin
      if (state_ff == S_GRAD) begin
         gx_ff <= signed'(gx_pos - gx_neg);
         gy_ff <= signed'(gy_pos - gy_neg);
      end
   end

   // Each square is taken at full width; the sum of both still fits the root input.
   assign gx_sq  = gx_ff * gx_ff;
   assign gy_sq  = gy_ff * gy_ff;
   assign square = unsigned'(gx_sq) + unsigned'(gy_sq);

   sed_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_SQ),
      .square(square),
      .done  (root_done),
      .root  (root)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: state_in = S_GRAD;
         S_GRAD: state_in = S_SQ;
         S_SQ:   state_in = S_ROOT;
         S_ROOT: if (root_done) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_ff.saturated     <= (root > ROOT_W'(255));
         rsp_ff.magnitude     <= (root > ROOT_W'(255)) ? 8'hFF : root[7:0];
         rsp_ff.window_inside <= inside_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ)) else $error("accepted item did not start a line read");

   a_sat_magnitude: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.saturated) |-> (rsp_payload.magnitude == 8'hFF))
      else $error("saturated item without full-scale magnitude");

   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      rows_ff != 2'd3) else $error("row count passed its limit");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(col_ff) < LINE_MAX) else $error("column count beyond the line store");

   a_root_only_busy: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == S_ROOT)) else $error("root result outside the root state");

endmodule
